// ===== sv/rmrct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmrct_pkg
// Shared types, constants and the raised-cosine edge table for the
// rectangular mask with a tapered edge.
// ----------------------------------------------------------------------------
package rmrct_pkg;

  localparam int COORD_BITS = 10;
  localparam int TBL_BITS   = 8;
  localparam int REG_BITS   = 14;
  localparam int ROM_SIZE   = (1 << TBL_BITS) + 1;
  localparam int Q_BITS     = TBL_BITS + 1;
  localparam int NUM_BITS   = REG_BITS + TBL_BITS + 1;
  localparam int M_BITS     = 17;
  localparam int CFG_IDX_BITS = 4;

  localparam logic [M_BITS-1:0] Q15_ONE = M_BITS'(32768);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X = 4'd0,
    CFG_CENTER_Y = 4'd1,
    CFG_CENTER_Z = 4'd2,
    CFG_HALF_X   = 4'd3,
    CFG_HALF_Y   = 4'd4,
    CFG_HALF_Z   = 4'd5,
    CFG_TAPER    = 4'd6,
    CFG_INVERT   = 4'd7
  } cfg_idx_t;

  typedef logic [15:0] rom_t [0:ROM_SIZE-1];

  // Side information that travels with each item down the pipeline.
  typedef struct packed {
    logic        valid;
    logic [15:0] re;
    logic [15:0] im;
    logic        hard;
    logic        in_box;
    logic        beyond;
    logic [2:0]  over;
  } side_t;

  // Shift by a power of two that rounds toward zero like a signed division.
  function automatic longint shr_trunc(longint n, int k);
    return (n < 0) ? -((-n) >>> k) : (n >>> k);
  endfunction

  // Division rounding toward zero by long division; the magnitudes stay
  // below 2^40 while the table is built.
  function automatic longint div_trunc(longint n, longint d);
    logic [39:0] un, ud, q, rm;
    logic        neg;
    neg = (n < 0) != (d < 0);
    un  = (n < 0) ? 40'(-n) : 40'(n);
    ud  = (d < 0) ? 40'(-d) : 40'(d);
    q   = '0;
    rm  = '0;
    for (int b = 39; b >= 0; b--) begin
      rm = {rm[38:0], un[b]};
      if (rm >= ud) begin
        rm   = rm - ud;
        q[b] = 1'b1;
      end
    end
    return neg ? -longint'({24'd0, q}) : longint'({24'd0, q});
  endfunction

  // cos^2 table built from a truncated Taylor series in Q30.
  function automatic rom_t build_rom();
    rom_t   r;
    longint a;
    longint a2;
    longint term;
    longint sum;
    for (int i = 0; i < ROM_SIZE; i++) begin
      a    = shr_trunc(64'sd1686629713 * longint'(i), TBL_BITS);
      a2   = shr_trunc(a * a, 30);
      term = 64'sd1 <<< 30;
      sum  = term;
      for (int n = 1; n <= 9; n++) begin
        term = -shr_trunc(term * a2, 30);
        term = div_trunc(term, longint'((2 * n - 1) * (2 * n)));
        sum  = sum + term;
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      r[i] = 16'((sum * sum + (64'sd1 <<< 44)) >>> 45);
    end
    return r;
  endfunction

  localparam rom_t EDGE_ROM = build_rom();

endpackage
`default_nettype wire

// ===== sv/rmrct_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmrct_div
// Pipelined restoring divider, one quotient bit per stage, for the edge
// table index of one axis.
// ----------------------------------------------------------------------------
module rmrct_div
  import rmrct_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [REG_BITS-1:0] tw,
  input  wire logic [NUM_BITS-1:0] num,
  output logic      [Q_BITS-1:0]   quo
);

  logic [NUM_BITS-1:0] rem [0:Q_BITS];
  logic [Q_BITS-1:0]   qr  [0:Q_BITS];

  assign rem[0] = num;
  assign qr[0]  = '0;

  for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
    logic [NUM_BITS-1:0] dv;
    logic                ge;
    assign dv = NUM_BITS'(tw) << (Q_BITS - 1 - j);
    assign ge = rem[j] >= dv;
    always_ff @(posedge clk) begin
      rem[j+1] <= ge ? rem[j] - dv : rem[j];
      qr[j+1]  <= qr[j] | (ge ? (Q_BITS'(1) << (Q_BITS - 1 - j)) : '0);
    end
  end

  assign quo = qr[Q_BITS];

endmodule
`default_nettype wire

// ===== sv/rect_mask_raised_cosine_taper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rect_mask_raised_cosine_taper
// Rectangular voxel mask with a raised-cosine edge, applied to a complex
// sample.
// ----------------------------------------------------------------------------
// Usage:
// An item (coordinates and a complex sample) is taken at a clock edge where
// start is high and busy is low. busy stays low, so one item can enter in
// every cycle. The result (mask_value, out_re, out_im) is marked by done for
// exactly one cycle. The depth is the distance stage, the band test, the
// nine-stage table-index divider of each axis, the table read, two mask
// multiplies, the mask select and the sample multiply. Throughput is one
// item per cycle.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write them only while no item is in
// flight. A synchronous reset clears the registers and every pipeline
// valid bit, so no stale result comes out. The receiver cannot stall, so
// the pipeline never holds.
// ----------------------------------------------------------------------------
module rect_mask_raised_cosine_taper
  import rmrct_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [COORD_BITS-1:0]   coord_x,
  input  wire logic [COORD_BITS-1:0]   coord_y,
  input  wire logic [COORD_BITS-1:0]   coord_z,
  input  wire logic signed [15:0]      sample_re,
  input  wire logic signed [15:0]      sample_im,
  output logic                         done,
  output logic [15:0]                  mask_value,
  output logic signed [15:0]           out_re,
  output logic signed [15:0]           out_im,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [REG_BITS-1:0]     cfg_data
);

  logic [REG_BITS-1:0] center [0:2];
  logic [REG_BITS-1:0] half   [0:2];
  logic [REG_BITS-1:0] taper;
  logic                invert;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0; center[1] <= '0; center[2] <= '0;
      half[0]   <= '0; half[1]   <= '0; half[2]   <= '0;
      taper     <= '0;
      invert    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X: center[0] <= cfg_data;
        CFG_CENTER_Y: center[1] <= cfg_data;
        CFG_CENTER_Z: center[2] <= cfg_data;
        CFG_HALF_X:   half[0]   <= cfg_data;
        CFG_HALF_Y:   half[1]   <= cfg_data;
        CFG_HALF_Z:   half[2]   <= cfg_data;
        CFG_TAPER:    taper     <= cfg_data;
        CFG_INVERT:   invert    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: per-axis distance in Q10.4.
  logic [COORD_BITS-1:0] coord [0:2];
  logic [REG_BITS-1:0]   adist [0:2];
  logic                  s1_valid;
  logic [15:0]           s1_re, s1_im;

  assign coord[0] = coord_x;
  assign coord[1] = coord_y;
  assign coord[2] = coord_z;

  for (genvar k = 0; k < 3; k++) begin : g_dist
    logic signed [REG_BITS:0] diff;
    assign diff = $signed({1'b0, coord[k], 4'b0000}) - $signed({1'b0, center[k]});
    always_ff @(posedge clk) begin
      adist[k] <= diff[REG_BITS] ? REG_BITS'(-diff) : diff[REG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= start;
    s1_re <= sample_re;
    s1_im <= sample_im;
  end

  // Stage 2: band tests and divider numerators.
  logic [NUM_BITS-1:0] num  [0:2];
  logic [2:0]          gt_r, past;
  side_t               s2;

  for (genvar k = 0; k < 3; k++) begin : g_band
    logic [REG_BITS-1:0] over;
    assign gt_r[k] = adist[k] > half[k];
    assign past[k] = {1'b0, adist[k]} > ({1'b0, half[k]} + {1'b0, taper});
    assign over    = adist[k] - half[k];
    always_ff @(posedge clk) begin
      num[k] <= (gt_r[k] && !past[k]) ?
                ((NUM_BITS'(over) << TBL_BITS) + NUM_BITS'(taper >> 1)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2.valid <= 1'b0;
    else     s2.valid <= s1_valid;
    s2.re     <= s1_re;
    s2.im     <= s1_im;
    s2.hard   <= taper == '0;
    s2.in_box <= gt_r == 3'b000;
    s2.beyond <= past != 3'b000;
    s2.over   <= gt_r;
  end

  // Divider stages: index = (over * 2^TBL_BITS + t/2) / t.
  logic [Q_BITS-1:0] idx [0:2];
  for (genvar k = 0; k < 3; k++) begin : g_div
    rmrct_div u_div (
      .clk (clk),
      .tw  (taper),
      .num (num[k]),
      .quo (idx[k])
    );
  end

  side_t side [0:Q_BITS];
  assign side[0] = s2;
  for (genvar j = 0; j < Q_BITS; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) side[j+1].valid <= 1'b0;
      else     side[j+1].valid <= side[j].valid;
      side[j+1].re     <= side[j].re;
      side[j+1].im     <= side[j].im;
      side[j+1].hard   <= side[j].hard;
      side[j+1].in_box <= side[j].in_box;
      side[j+1].beyond <= side[j].beyond;
      side[j+1].over   <= side[j].over;
    end
  end

  // Table read; an axis outside its band contributes one.
  logic [M_BITS-1:0] fac [0:2];
  side_t             s_rom;
  for (genvar k = 0; k < 3; k++) begin : g_rom
    logic [Q_BITS-1:0] ix;
    // A zero taper leaves an all-ones quotient; keep the read inside the table.
    assign ix = (idx[k] > Q_BITS'(ROM_SIZE - 1)) ? Q_BITS'(ROM_SIZE - 1) : idx[k];
    always_ff @(posedge clk) begin
      fac[k] <= side[Q_BITS].over[k] ? M_BITS'(EDGE_ROM[ix]) : Q15_ONE;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s_rom.valid <= 1'b0;
    else     s_rom.valid <= side[Q_BITS].valid;
    s_rom.re     <= side[Q_BITS].re;
    s_rom.im     <= side[Q_BITS].im;
    s_rom.hard   <= side[Q_BITS].hard;
    s_rom.in_box <= side[Q_BITS].in_box;
    s_rom.beyond <= side[Q_BITS].beyond;
    s_rom.over   <= side[Q_BITS].over;
  end

  // The first factor times one is the factor itself, so two multiplies remain.
  logic [2*M_BITS-1:0] prod_a, prod_b;
  logic [M_BITS-1:0]   m_a, m_b, fac_z;
  side_t               s_a, s_b;

  assign prod_a = fac[0] * fac[1] + (2*M_BITS)'(16384);
  always_ff @(posedge clk) begin
    m_a   <= prod_a[15 +: M_BITS];
    fac_z <= fac[2];
    if (rst) s_a <= '0;
    else     s_a <= s_rom;
  end

  assign prod_b = m_a * fac_z + (2*M_BITS)'(16384);
  always_ff @(posedge clk) begin
    m_b <= prod_b[15 +: M_BITS];
    if (rst) s_b <= '0;
    else     s_b <= s_a;
  end

  // Mask select and inversion.
  logic [M_BITS-1:0] m_sel, m_fin;
  side_t             s_m;
  always_comb begin
    if (s_b.hard)        m_sel = s_b.in_box ? Q15_ONE : '0;
    else if (s_b.beyond) m_sel = '0;
    else if (s_b.in_box) m_sel = Q15_ONE;
    else                 m_sel = m_b;
  end
  always_ff @(posedge clk) begin
    m_fin <= invert ? Q15_ONE - m_sel : m_sel;
    if (rst) s_m <= '0;
    else     s_m <= s_b;
  end

  // Sample scaling with round half up.
  logic signed [2*M_BITS-1:0] p_re, p_im;
  assign p_re = $signed({{(M_BITS-15){s_m.re[15]}}, s_m.re}) * $signed({1'b0, m_fin})
                + $signed((2*M_BITS)'(16384));
  assign p_im = $signed({{(M_BITS-15){s_m.im[15]}}, s_m.im}) * $signed({1'b0, m_fin})
                + $signed((2*M_BITS)'(16384));

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= s_m.valid;
    mask_value <= m_fin[15:0];
    out_re     <= p_re[30:15];
    out_im     <= p_im[30:15];
  end

endmodule
`default_nettype wire

// ===== sv/rmrct_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmrct_checker
// Port-level checks of the masked-sample pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rmrct_checker
  import rmrct_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic signed [15:0]      sample_re,
  input wire logic                    done,
  input wire logic [15:0]             mask_value,
  input wire logic signed [15:0]      out_re,
  input wire logic signed [15:0]      out_im
);

  localparam int LAT = 16;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised on a fully pipelined block");

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without an item accepted at the pipeline depth");

  a_mask_range: assert property (@(posedge clk) disable iff (rst)
    done |-> mask_value <= 16'd32768)
    else $error("mask above one");

  a_zero_mask: assert property (@(posedge clk) disable iff (rst)
    (done && mask_value == 16'd0) |-> (out_re == 16'sd0 && out_im == 16'sd0))
    else $error("nonzero output under a zero mask");

  a_unit_mask: assert property (@(posedge clk) disable iff (rst)
    (done && mask_value == 16'd32768) |-> out_re == $past(sample_re, LAT))
    else $error("unit mask changed the sample");

endmodule

bind rect_mask_raised_cosine_taper rmrct_checker u_rmrct_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .sample_re  (sample_re),
  .done       (done),
  .mask_value (mask_value),
  .out_re     (out_re),
  .out_im     (out_im)
);
`default_nettype wire
